### rtl/nmea_sentence_framer_checker_assert.svh
// Assertion macros for the sentence framer.
// NSFC_ASSERT checks out of reset; NSFC_ASSERT_ANY checks on every edge.
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define NSFC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nsfc assertion failed");
`define NSFC_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("nsfc assertion failed");
`else
`define NSFC_ASSERT(label, clk, rst_n, prop)
`define NSFC_ASSERT_ANY(label, clk, prop)
`endif
`endif

### rtl/nsfc_pkg.sv
package nsfc_pkg;

    localparam int LINE_CAPACITY_DEF = 256;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [15:0] TALK_GP  = "GP";
    localparam logic [15:0] TALK_GN  = "GN";
    localparam logic [23:0] TYPE_GGA = "GGA";
    localparam logic [23:0] TYPE_RMC = "RMC";
    localparam logic [23:0] TYPE_VTG = "VTG";

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GGA   = 2'd1;
    localparam logic [1:0] KIND_RMC   = 2'd2;
    localparam logic [1:0] KIND_VTG   = 2'd3;

    localparam logic STAT_CLOSED  = 1'b0;
    localparam logic STAT_OVERLONG = 1'b1;

    typedef struct packed {
        logic       status;
        logic       checksum_ok;
        logic [1:0] kind;
        logic [7:0] computed;
        logic [7:0] stated;
        logic [7:0] length;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

### rtl/nmea_sentence_framer_checker.sv
// A byte beat accepted into the input register passes the state update into the
// result register and shows on o_valid when that byte closes or discards a sentence.
// Throughput: one byte beat per cycle; the state update sits between the input
// register and the result register, and o_stall rises only while a byte is
// held and a finished result beat waits under i_stall.
// Reset: synchronous, active low on i_rst_n; clears sentence state and valids.
`include "nmea_sentence_framer_checker_assert.svh"

module nmea_sentence_framer_checker #(
    parameter int LINE_CAPACITY = nsfc_pkg::LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte beats in
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // result beats out
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_status,
    output logic       o_checksum_ok,
    output logic [1:0] o_sentence_kind,
    output logic [7:0] o_computed_checksum,
    output logic [7:0] o_rx_checksum,
    output logic [7:0] o_sentence_length
);

    // Input register: holds one byte beat waiting for the state update.
    logic              r_in_valid;
    logic [7:0]        r_in_byte;

    // Result register: holds one finished result beat for the consumer.
    logic              r_out_valid;
    nsfc_pkg::t_result r_out;

    logic              go;
    logic              res_valid;
    nsfc_pkg::t_result res;

    // The held byte moves into the state unless a result is parked and stalled.
    assign go      = r_in_valid && !(r_out_valid && i_stall);
    // Input side waits only while the held byte cannot move on.
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Framing, XOR, hex and header tracking; emits at '\n' or on overflow.
    nsfc_core #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // When go is high the result register is empty or drains this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_out.status;
    assign o_checksum_ok       = r_out.checksum_ok;
    assign o_sentence_kind     = r_out.kind;
    assign o_computed_checksum = r_out.computed;
    assign o_rx_checksum       = r_out.stated;
    assign o_sentence_length   = r_out.length;

    // Nothing pending right after reset.
    `NSFC_ASSERT_ANY(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid)
    // Back-pressure to the source only comes from a stalled, full result register.
    `NSFC_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall))
    // A discarded sentence carries no verdict, kind or checksums.
    `NSFC_ASSERT(a_discard_fields, i_clk, i_rst_n,
        (o_valid && o_status == nsfc_pkg::STAT_OVERLONG) |->
        (!o_checksum_ok && o_sentence_kind == nsfc_pkg::KIND_OTHER &&
         o_computed_checksum == 8'd0 && o_rx_checksum == 8'd0))
    // A good verdict means the received and computed sums agree.
    `NSFC_ASSERT(a_ok_means_match, i_clk, i_rst_n,
        (o_valid && o_checksum_ok) |-> (o_computed_checksum == o_rx_checksum))

endmodule

### rtl/nsfc_core.sv
module nsfc_core #(
    parameter int LINE_CAPACITY = nsfc_pkg::LINE_CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output nsfc_pkg::t_result o_res
);

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] LAST = CW'(LINE_CAPACITY - 1);

    logic            r_in_sentence, n_in_sentence;
    logic [CW-1:0]   r_char_count, n_char_count;
    logic [7:0]      r_xor, n_xor;
    logic            r_xor_stopped, n_xor_stopped;
    logic            r_star_seen, n_star_seen;
    logic [1:0]      r_after_star, n_after_star;
    logic [7:0]      r_hex_value, n_hex_value;
    logic [1:0]      r_hex_count, n_hex_count;
    logic            r_hex_stopped, n_hex_stopped;
    logic            r_zero_seen, n_zero_seen;
    logic [7:0]      r_hdr [5];
    logic [7:0]      n_hdr [5];

    logic [4:0]      hex_d;
    logic [2:0]      hdr_idx;
    logic            hdr_wr;
    logic [CW+7:0]   len_ext;
    logic            talker_ok;
    logic [23:0]     msg_type;
    logic [1:0]      kind;

    assign hex_d   = nsfc_pkg::hex_decode(i_byte);
    assign hdr_idx = r_char_count[2:0] - 3'd1;
    assign hdr_wr  = (r_char_count >= CW'(1)) && (r_char_count <= CW'(5));
    assign len_ext = {8'd0, r_char_count};

    assign talker_ok = (r_hdr[0] == "G") &&
                       ((r_hdr[1] == nsfc_pkg::TALK_GP[7:0]) ||
                        (r_hdr[1] == nsfc_pkg::TALK_GN[7:0]));
    assign msg_type  = {r_hdr[2], r_hdr[3], r_hdr[4]};

    always_comb begin
        kind = nsfc_pkg::KIND_OTHER;
        if (talker_ok) begin
            if (msg_type == nsfc_pkg::TYPE_GGA) begin
                kind = nsfc_pkg::KIND_GGA;
            end else if (msg_type == nsfc_pkg::TYPE_RMC) begin
                kind = nsfc_pkg::KIND_RMC;
            end else if (msg_type == nsfc_pkg::TYPE_VTG) begin
                kind = nsfc_pkg::KIND_VTG;
            end
        end
    end

    always_comb begin
        n_in_sentence = r_in_sentence;
        n_char_count  = r_char_count;
        n_xor         = r_xor;
        n_xor_stopped = r_xor_stopped;
        n_star_seen   = r_star_seen;
        n_after_star  = r_after_star;
        n_hex_value   = r_hex_value;
        n_hex_count   = r_hex_count;
        n_hex_stopped = r_hex_stopped;
        n_zero_seen   = r_zero_seen;
        n_hdr         = r_hdr;
        o_res_valid   = 1'b0;
        o_res         = '0;

        if (i_go) begin
            if (i_byte == nsfc_pkg::CH_DOLLAR) begin
                // '$' restarts, dropping any open sentence
                n_in_sentence = 1'b1;
                n_char_count  = CW'(1);
                n_xor         = 8'd0;
                n_xor_stopped = 1'b0;
                n_star_seen   = 1'b0;
                n_after_star  = 2'd0;
                n_hex_value   = 8'd0;
                n_hex_count   = 2'd0;
                n_hex_stopped = 1'b0;
                n_zero_seen   = 1'b0;
                n_hdr         = '{default: 8'd0};
            end else if (r_in_sentence) begin
                if (i_byte == nsfc_pkg::CH_LF || r_char_count >= LAST) begin
                    o_res_valid = 1'b1;
                    o_res.length = len_ext[7:0];
                    if (i_byte == nsfc_pkg::CH_LF) begin
                        o_res.status      = nsfc_pkg::STAT_CLOSED;
                        o_res.checksum_ok = r_star_seen && (r_after_star == 2'd2) &&
                                            (r_hex_count != 2'd0) &&
                                            (r_hex_value == r_xor);
                        o_res.kind        = kind;
                        o_res.computed    = r_xor;
                        o_res.stated      = r_hex_value;
                    end else begin
                        o_res.status = nsfc_pkg::STAT_OVERLONG;
                    end
                    n_in_sentence = 1'b0;
                    n_char_count  = '0;
                    n_xor         = 8'd0;
                    n_xor_stopped = 1'b0;
                    n_star_seen   = 1'b0;
                    n_after_star  = 2'd0;
                    n_hex_value   = 8'd0;
                    n_hex_count   = 2'd0;
                    n_hex_stopped = 1'b0;
                    n_zero_seen   = 1'b0;
                    n_hdr         = '{default: 8'd0};
                end else begin
                    n_char_count = r_char_count + CW'(1);
                    if (!r_zero_seen) begin
                        if (i_byte == nsfc_pkg::CH_NUL) begin
                            n_zero_seen = 1'b1;
                        end else begin
                            if (!r_xor_stopped) begin
                                if (i_byte == nsfc_pkg::CH_STAR ||
                                    i_byte == nsfc_pkg::CH_CR) begin
                                    n_xor_stopped = 1'b1;
                                end else begin
                                    n_xor = r_xor ^ i_byte;
                                end
                            end
                            if (hdr_wr) begin
                                n_hdr[hdr_idx] = i_byte;
                            end
                            if (r_star_seen) begin
                                if (r_after_star != 2'd2) begin
                                    n_after_star = r_after_star + 2'd1;
                                end
                                if (!r_hex_stopped && r_hex_count != 2'd2) begin
                                    if (!hex_d[4]) begin
                                        n_hex_stopped = 1'b1;
                                    end else begin
                                        n_hex_value = {r_hex_value[3:0], hex_d[3:0]};
                                        n_hex_count = r_hex_count + 2'd1;
                                    end
                                end
                            end else if (i_byte == nsfc_pkg::CH_STAR) begin
                                n_star_seen = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_char_count  <= '0;
            r_xor         <= 8'd0;
            r_xor_stopped <= 1'b0;
            r_star_seen   <= 1'b0;
            r_after_star  <= 2'd0;
            r_hex_value   <= 8'd0;
            r_hex_count   <= 2'd0;
            r_hex_stopped <= 1'b0;
            r_zero_seen   <= 1'b0;
            r_hdr         <= '{default: 8'd0};
        end else begin
            r_in_sentence <= n_in_sentence;
            r_char_count  <= n_char_count;
            r_xor         <= n_xor;
            r_xor_stopped <= n_xor_stopped;
            r_star_seen   <= n_star_seen;
            r_after_star  <= n_after_star;
            r_hex_value   <= n_hex_value;
            r_hex_count   <= n_hex_count;
            r_hex_stopped <= n_hex_stopped;
            r_zero_seen   <= n_zero_seen;
            r_hdr         <= n_hdr;
        end
    end

endmodule

### verif/tb_nmea_sentence_framer_checker.sv
module tb_nmea_sentence_framer_checker;
    timeunit 1ns;
    timeprecision 1ps;

    // Store depth matches the block's default parameter
    localparam int LINE_CAP = nsfc_pkg::LINE_CAPACITY_DEF;
    // Random byte budget for the four handshake phases, boundary bytes counted in
    localparam int RAND_BYTES = 1450;
    localparam int NUM_PHASES = 4;
    // Generous wall, far above the slowest legal run
    localparam int RUN_LIMIT_NS = 2_000_000;

    // How a generated sentence ends
    typedef enum int {
        TAIL_GOOD,       // '*', two correct hex digits
        TAIL_BAD,        // '*', two wrong hex digits
        TAIL_NO_STAR,    // no checksum at all
        TAIL_ONE_DIGIT,  // '*', a single hex digit
        TAIL_NON_HEX,    // '*', a non-hex character first
        TAIL_TWO_STARS,  // '*', '*', then the digits
        TAIL_OPEN        // never closed, the next '$' cuts it
    } t_tail;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_status;
    logic       o_checksum_ok;
    logic [1:0] o_sentence_kind;
    logic [7:0] o_computed_checksum;
    logic [7:0] o_rx_checksum;
    logic [7:0] o_sentence_length;

    nmea_sentence_framer_checker #(
        .LINE_CAPACITY(LINE_CAP)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_rx_byte           (i_rx_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_status            (o_status),
        .o_checksum_ok       (o_checksum_ok),
        .o_sentence_kind     (o_sentence_kind),
        .o_computed_checksum (o_computed_checksum),
        .o_rx_checksum       (o_rx_checksum),
        .o_sentence_length   (o_sentence_length)
    );

    // Byte beats waiting to go out, and sentence reports waiting to come back
    logic [7:0]        byte_q[$];
    nsfc_pkg::t_result report_q[$];

    // Handshake pressure of the current phase, in percent of cycles
    int idle_pct = 0;
    int stall_pct = 0;

    // Run statistics
    int n_errors = 0;
    int n_beats = 0;
    int n_reports = 0;
    int n_ok = 0;
    int n_overlong = 0;
    int kind_cnt[4] = '{0, 0, 0, 0};

    // Shadow of the framer: sentence state kept in step with accepted beats
    bit         in_frame;
    int         held;          // characters held, '$' included
    logic [7:0] xor_acc;
    bit         xor_done;      // stopped at first '*' or CR
    bit         star_seen;
    int         after_star;    // saturates at 2
    logic [7:0] hex_acc;
    int         hex_digits;
    bit         hex_done;
    bit         nul_seen;      // a zero byte ends the content
    logic [7:0] hdr[5];        // header characters 1..5

    nsfc_pkg::t_result fresh_report;
    nsfc_pkg::t_result oldest;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic void clear_frame();
        in_frame   = 1'b0;
        held       = 0;
        xor_acc    = 8'h00;
        xor_done   = 1'b0;
        star_seen  = 1'b0;
        after_star = 0;
        hex_acc    = 8'h00;
        hex_digits = 0;
        hex_done   = 1'b0;
        nul_seen   = 1'b0;
        foreach (hdr[i]) hdr[i] = 8'h00;
    endfunction

    // Value of an ASCII hex digit, -1 when the byte is not one
    function automatic int nibble_of(input logic [7:0] b);
        if (b inside {["0":"9"]}) return int'(b) - int'("0");
        if (b inside {["a":"f"]}) return int'(b) - int'("a") + 10;
        if (b inside {["A":"F"]}) return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    // Advances the shadow framer by one byte; returns 1 with the report
    // when that byte closes or discards a sentence.
    function automatic bit frame_byte(input logic [7:0] b, output nsfc_pkg::t_result r);
        int          pos;
        int          nib;
        logic [15:0] talker;
        logic [23:0] msg_type;
        r = '0;
        if (b == nsfc_pkg::CH_DOLLAR) begin
            // '$' always restarts, an open sentence is dropped silently
            clear_frame();
            in_frame = 1'b1;
            held     = 1;
            return 1'b0;
        end
        if (!in_frame) return 1'b0;

        if (b == nsfc_pkg::CH_LF) begin
            talker   = {hdr[0], hdr[1]};
            msg_type = {hdr[2], hdr[3], hdr[4]};
            r.status      = nsfc_pkg::STAT_CLOSED;
            r.checksum_ok = star_seen && after_star >= 2 && hex_digits >= 1 &&
                            hex_acc == xor_acc;
            r.kind = nsfc_pkg::KIND_OTHER;
            if (talker == nsfc_pkg::TALK_GP || talker == nsfc_pkg::TALK_GN) begin
                if (msg_type == nsfc_pkg::TYPE_GGA)      r.kind = nsfc_pkg::KIND_GGA;
                else if (msg_type == nsfc_pkg::TYPE_RMC) r.kind = nsfc_pkg::KIND_RMC;
                else if (msg_type == nsfc_pkg::TYPE_VTG) r.kind = nsfc_pkg::KIND_VTG;
            end
            r.computed = xor_acc;
            r.stated   = hex_acc;
            r.length   = 8'(held);
            clear_frame();
            return 1'b1;
        end

        if (held < LINE_CAP - 1) begin
            pos  = held;
            held = held + 1;
            if (nul_seen) return 1'b0;
            if (b == nsfc_pkg::CH_NUL) begin
                nul_seen = 1'b1;
                return 1'b0;
            end
            if (!xor_done) begin
                if (b == nsfc_pkg::CH_STAR || b == nsfc_pkg::CH_CR) xor_done = 1'b1;
                else xor_acc = xor_acc ^ b;
            end
            if (pos >= 1 && pos <= 5) hdr[pos - 1] = b;
            if (star_seen) begin
                if (after_star < 2) after_star++;
                if (!hex_done && hex_digits < 2) begin
                    nib = nibble_of(b);
                    if (nib < 0) begin
                        hex_done = 1'b1;
                    end else begin
                        hex_acc = {hex_acc[3:0], 4'(nib)};
                        hex_digits++;
                    end
                end
            end else if (b == nsfc_pkg::CH_STAR) begin
                star_seen = 1'b1;
            end
            return 1'b0;
        end

        // Line store full: anything but '$' or LF throws the sentence away
        r.status = nsfc_pkg::STAT_OVERLONG;
        r.length = 8'(held);
        clear_frame();
        return 1'b1;
    endfunction

    // Driver: byte beats from byte_q, valid held steady through a stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_rx_byte <= 8'h00;
            clear_frame();
        end else begin
            if (i_valid && !o_stall) begin
                n_beats++;
                if (frame_byte(i_rx_byte, fresh_report)) begin
                    report_q.push_back(fresh_report);
                end
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_valid   <= 1'b1;
                    i_rx_byte <= byte_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every accepted result beat checked against the oldest report
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (report_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "result beat with no sentence report pending (length %0d)",
                        o_sentence_length));
                end else begin
                    oldest = report_q.pop_front();
                    n_reports++;
                    if (oldest.checksum_ok) n_ok++;
                    if (oldest.status == nsfc_pkg::STAT_OVERLONG) n_overlong++;
                    else kind_cnt[oldest.kind]++;
                    if (o_status !== oldest.status)
                        report_mismatch($sformatf("status got %0b want %0b",
                            o_status, oldest.status));
                    if (o_checksum_ok !== oldest.checksum_ok)
                        report_mismatch($sformatf("checksum_ok got %0b want %0b",
                            o_checksum_ok, oldest.checksum_ok));
                    if (o_sentence_kind !== oldest.kind)
                        report_mismatch($sformatf("sentence_kind got %0d want %0d",
                            o_sentence_kind, oldest.kind));
                    if (o_computed_checksum !== oldest.computed)
                        report_mismatch($sformatf("computed_checksum got %h want %h",
                            o_computed_checksum, oldest.computed));
                    if (o_rx_checksum !== oldest.stated)
                        report_mismatch($sformatf("rx_checksum got %h want %h",
                            o_rx_checksum, oldest.stated));
                    if (o_sentence_length !== oldest.length)
                        report_mismatch($sformatf("sentence_length got %0d want %0d",
                            o_sentence_length, oldest.length));
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 10) return 8'("0") + 8'(n);
        return (lower ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
    endfunction

    // Printable filler that never opens a sentence or a checksum
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(32, 126));
        if (c == nsfc_pkg::CH_DOLLAR || c == nsfc_pkg::CH_STAR) c = 8'(",");
        return c;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endtask

    task automatic push_body(ref logic [7:0] body[$], input string s);
        for (int i = 0; i < s.len(); i++) body.push_back(s[i]);
    endtask

    // Queues '$', the body and the chosen ending; n returns the byte count
    task automatic emit_frame(input logic [7:0] body[$], input t_tail tail,
                              output int n);
        logic [7:0] sum;
        logic [7:0] frame[$];
        bit         lower;
        sum   = 8'h00;
        lower = 1'($urandom_range(1));
        foreach (body[i]) sum = sum ^ body[i];
        frame.push_back(nsfc_pkg::CH_DOLLAR);
        foreach (body[i]) frame.push_back(body[i]);
        case (tail)
            TAIL_GOOD, TAIL_BAD: begin
                if (tail == TAIL_BAD) sum = sum ^ 8'($urandom_range(1, 255));
                frame.push_back(nsfc_pkg::CH_STAR);
                frame.push_back(hex_char(sum[7:4], lower));
                frame.push_back(hex_char(sum[3:0], lower));
            end
            TAIL_ONE_DIGIT: begin
                frame.push_back(nsfc_pkg::CH_STAR);
                frame.push_back(hex_char(sum[3:0], lower));
            end
            TAIL_NON_HEX: begin
                frame.push_back(nsfc_pkg::CH_STAR);
                frame.push_back(8'($urandom_range(int'("G"), int'("Z"))));
                frame.push_back(hex_char(sum[3:0], lower));
            end
            TAIL_TWO_STARS: begin
                frame.push_back(nsfc_pkg::CH_STAR);
                frame.push_back(nsfc_pkg::CH_STAR);
                frame.push_back(hex_char(sum[7:4], lower));
                frame.push_back(hex_char(sum[3:0], lower));
            end
            default: ;
        endcase
        if (tail != TAIL_OPEN) begin
            if ($urandom_range(1)) frame.push_back(nsfc_pkg::CH_CR);
            frame.push_back(nsfc_pkg::CH_LF);
        end
        foreach (frame[i]) byte_q.push_back(frame[i]);
        n = frame.size();
    endtask

    // One random sentence: mostly well formed, the rest broken or noise-like
    task automatic gen_sentence(output int n);
        logic [7:0] body[$];
        logic [7:0] stray;
        int         pick;
        int         mode;
        int         nf;
        t_tail      tail;
        n = 0;
        // stray bytes between sentences, ignored when nothing is open
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3)) begin
                stray = 8'($urandom_range(255));
                if (stray == nsfc_pkg::CH_DOLLAR) stray = nsfc_pkg::CH_LF;
                byte_q.push_back(stray);
            end
        end
        mode = $urandom_range(99);
        if (mode < 8) begin
            // raw bytes, every value allowed
            repeat ($urandom_range(1, 24)) body.push_back(8'($urandom_range(255)));
        end else if (mode < 9) begin
            // near or past the line store
            repeat ($urandom_range(LINE_CAP - 6, LINE_CAP + 4))
                body.push_back(text_char());
        end else begin
            pick = $urandom_range(9);
            if (pick < 4) push_body(body, "GP");
            else if (pick < 8) push_body(body, "GN");
            else repeat (2) body.push_back(8'($urandom_range(int'("A"), int'("Z"))));
            pick = $urandom_range(9);
            if (pick < 3) push_body(body, "GGA");
            else if (pick < 6) push_body(body, "RMC");
            else if (pick < 8) push_body(body, "VTG");
            else repeat ($urandom_range(0, 3))
                body.push_back(8'($urandom_range(int'("A"), int'("Z"))));
            nf = $urandom_range(0, 5);
            repeat (nf) begin
                body.push_back(8'(","));
                repeat ($urandom_range(0, 6)) body.push_back(text_char());
            end
            // zero byte buried in the content
            if ($urandom_range(99) < 6 && body.size() > 1)
                body.insert($urandom_range(1, body.size() - 1), nsfc_pkg::CH_NUL);
        end
        pick = $urandom_range(99);
        if (pick < 62)      tail = TAIL_GOOD;
        else if (pick < 72) tail = TAIL_BAD;
        else if (pick < 78) tail = TAIL_NO_STAR;
        else if (pick < 84) tail = TAIL_ONE_DIGIT;
        else if (pick < 89) tail = TAIL_NON_HEX;
        else if (pick < 94) tail = TAIL_TWO_STARS;
        else                tail = TAIL_OPEN;
        emit_frame(body, tail, n);
    endtask

    // Wait until every queued beat went out and every report came back
    task automatic drain();
        while (byte_q.size() != 0 || i_valid || report_q.size() != 0)
            @(posedge i_clk);
        // bytes that give no result may still sit in the pipeline
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout: %0d reports still pending", report_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int         idle_tbl[NUM_PHASES];
        int         stall_tbl[NUM_PHASES];
        int         budget;
        int         n;
        logic [7:0] body[$];
        idle_tbl  = '{0, 56, 0, 7};
        stall_tbl = '{0, 0, 56, 7};
        budget    = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: bytes outside any sentence are ignored, extremes included
        byte_q.push_back(8'hFF);
        byte_q.push_back(nsfc_pkg::CH_NUL);
        byte_q.push_back(8'("A"));
        byte_q.push_back(nsfc_pkg::CH_LF);
        // '$' inside an open sentence restarts it
        push_text("$GP");
        push_body(body, "GNVTG,1");
        emit_frame(body, TAIL_GOOD, n);
        body.delete();
        push_body(body, "GPGGA");
        emit_frame(body, TAIL_ONE_DIGIT, n);
        // zero byte ends the content, CR after it is length only
        push_text("$A");
        byte_q.push_back(nsfc_pkg::CH_NUL);
        push_text("B*");
        byte_q.push_back(nsfc_pkg::CH_CR);
        byte_q.push_back(nsfc_pkg::CH_LF);
        body.delete();
        push_body(body, "GPRMC");
        emit_frame(body, TAIL_NON_HEX, n);
        body.delete();
        push_body(body, "XX");
        emit_frame(body, TAIL_TWO_STARS, n);
        body.delete();
        body.push_back(8'hFF);
        body.push_back(8'h80);
        emit_frame(body, TAIL_GOOD, n);

        // Store boundary: the largest sentence that still closes (if no CR is added), then
        // one byte more, which is discarded (its LF lands outside)
        body.delete();
        repeat (LINE_CAP - 2) body.push_back(text_char());
        emit_frame(body, TAIL_NO_STAR, n);
        budget += n;
        body.push_back(text_char());
        emit_frame(body, TAIL_NO_STAR, n);
        budget += n;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];
            while (budget < (ph + 1) * RAND_BYTES / NUM_PHASES) begin
                gen_sentence(n);
                budget += n;
            end
            drain();
        end
        idle_pct  = 0;
        stall_pct = 0;
        repeat (10) @(posedge i_clk);

        if (report_q.size() != 0)
            report_mismatch($sformatf("%0d sentence reports never arrived",
                                      report_q.size()));
        $display("Run covered %0d byte beats and %0d sentence reports",
                 n_beats, n_reports);
        $display("  checksum good %0d, overlong %0d, GGA %0d RMC %0d VTG %0d other %0d",
                 n_ok, n_overlong, kind_cnt[nsfc_pkg::KIND_GGA],
                 kind_cnt[nsfc_pkg::KIND_RMC], kind_cnt[nsfc_pkg::KIND_VTG],
                 kind_cnt[nsfc_pkg::KIND_OTHER]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
